>>> hdl/plln_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plln_pkg
// Shared types, constants and the arctangent table for the pilot PLL / NCO.
// ----------------------------------------------------------------------------
package plln_pkg;

    localparam int PHASE_FRACTION_BITS_DEF = 32;
    localparam int SAMPLE_WIDTH_DEF        = 16;
    localparam int CORDIC_STEPS_DEF        = 16;

    // loop gain coefficients, Q.16
    localparam logic [17:0] KP_COEF = 18'd174719;
    localparam logic [17:0] KI_COEF = 18'd232980;

    // CORDIC seed, pre-divided by the rotation gain
    localparam logic [31:0] CORDIC_X0 = 32'd652032874;

    localparam logic [31:0] RST_PHASE_INC = 32'd340018244;
    localparam logic [6:0]  RST_NCO_SCALE = 7'd32;
    localparam logic [31:0] RST_PHASE_ADJ = 32'd0;
    localparam logic [15:0] RST_LOOP_BW   = 16'd655;
    localparam logic signed [15:0] TRIG_ONE = 16'sd32767;

    typedef enum logic [1:0] {
        REG_PHASE_INC = 2'd0,
        REG_NCO_SCALE = 2'd1,
        REG_PHASE_ADJ = 2'd2,
        REG_LOOP_BW   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_VEC_GO,
        ST_VEC_WAIT,
        ST_GAIN_KP,
        ST_GAIN_SQ,
        ST_GAIN_KI,
        ST_ERR_KI,
        ST_ERR_KP,
        ST_UPDATE,
        ST_ROT1_GO,
        ST_ROT1_WAIT,
        ST_ROT1_FIN,
        ST_SCALE,
        ST_ROT2_GO,
        ST_ROT2_WAIT,
        ST_ROT2_FIN
    } plln_state_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in cycles times 2^32
    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933405;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> hdl/plln_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plln_cordic
// Shared CORDIC unit, one micro-rotation per clock, vectoring or rotation.
// ----------------------------------------------------------------------------
module plln_cordic import plln_pkg::*; #(
    parameter int CW    = 34,
    parameter int ZW    = 34,
    parameter int FRAC  = PHASE_FRACTION_BITS_DEF,
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cordic_cmd_t          cmd,
    input  wire logic signed [CW-1:0] x_in,
    input  wire logic signed [CW-1:0] y_in,
    input  wire logic signed [ZW-1:0] z_in,
    output cordic_stat_t              stat,
    output logic signed [CW-1:0]      x_out,
    output logic signed [CW-1:0]      y_out,
    output logic signed [ZW-1:0]      z_out
);

    localparam int NW = $clog2(STEPS);
    localparam int SL = (FRAC >= 32) ? FRAC - 32 : 0;
    localparam int SR = (FRAC >= 32) ? 0 : 32 - FRAC;

    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [NW-1:0]        iter_reg;
    logic                 busy_reg, done_reg, vec_reg;

    logic signed [CW-1:0] dx, dy;
    logic [63:0]          a_wide;
    logic signed [ZW-1:0] a;
    logic                 up;

    always_comb begin
        dx     = y_reg >>> iter_reg;
        dy     = x_reg >>> iter_reg;
        a_wide = (64'(atan_at(5'(iter_reg))) << SL) >> SR;
        a      = ZW'(a_wide);
        // vectoring drives y to zero, rotation drives z to zero
        up     = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
        if (up) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - a;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == NW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            z_reg   <= z_in;
            vec_reg <= cmd.vectoring;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule
`default_nettype wire

>>> hdl/pilot_pll_quadrature_nco.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pilot_pll_quadrature_nco
// Pilot-tone PLL with PI loop filter and quadrature NCO output.
// ----------------------------------------------------------------------------
// Each sample beat takes one pass through the sequencer: one CORDIC unit, one
// micro-rotation per clock, is used three times per sample (phase error atan2,
// feedback sine/cosine, output sine/cosine), with the loop-filter products in
// registered steps between, and the atan2 pass is skipped when the error
// vector is zero and the phase error is then taken as zero.
// s_ready is high only in idle with room in the output register. The result
// beat carries the sine and cosine computed for the previous sample and is
// presented the cycle after the sample is accepted. Registers sit on an APB
// port at byte addresses 0, 4, 8 and 12 and must only be written while idle.
module pilot_pll_quadrature_nco import plln_pkg::*; #(
    parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF,
    parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [15:0]                  m_nco_cos,
    output logic signed [15:0]                  m_nco_sin,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [3:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int F   = PHASE_FRACTION_BITS;
    localparam int SW  = SAMPLE_WIDTH;
    localparam int PB  = F + 4;
    localparam int PW  = SW + 16;
    localparam int CW  = (SW + 18 > 34) ? SW + 18 : 34;
    localparam int ZW  = F + 2;
    localparam int KIP = F + 23;
    localparam int KPP = F + 19;
    localparam int IW  = (F + 5 > 34) ? F + 5 : 34;
    localparam int EW  = ((PB > 32) ? PB : 32) + 1;
    localparam int SL  = (F >= 32) ? F - 32 : 0;
    localparam int SR  = (F >= 32) ? 0 : 32 - F;
    localparam logic signed [IW-1:0] SAT_HI = IW'(64'sh7FFF_FFFF);
    localparam logic signed [IW-1:0] SAT_LO = IW'(-64'sh8000_0000);

    // configuration
    logic [31:0] inc_reg, adj_reg;
    logic [6:0]  scale_reg;
    logic [15:0] bw_reg;

    // sequencer and datapath
    plln_state_t           state_reg, state_next;
    logic signed [SW-1:0]  smp_reg;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic signed [F-1:0]   err_reg;
    logic [17:0]           kp_reg;
    logic [31:0]           sq_reg;
    logic [21:0]           ki_reg;
    logic signed [PB-1:0]  kiterm_reg, kpterm_reg;
    logic signed [31:0]    integ_reg;
    logic [PB-1:0]         est_reg, sph_reg, arg_reg;
    logic [F-1:0]          oph_reg;
    logic [1:0]            q_reg;
    logic signed [15:0]    fc_reg, fs_reg, hc_reg, hs_reg;
    logic                  m_valid_reg;
    logic signed [15:0]    m_cos_reg, m_sin_reg;

    cordic_cmd_t           cmd;
    cordic_stat_t          stat;
    logic signed [CW-1:0]  cx_in, cy_in, cx_out, cy_out;
    logic signed [ZW-1:0]  cz_in, cz_out;

    logic                  accept, vec_zero;
    logic signed [CW-1:0]  vx, vy;
    logic [F-1:0]          tp, tsum, tdiff;
    logic [1:0]            tq;
    logic signed [15:0]    cr, sr, tc, ts;
    logic signed [KIP-1:0] kiprod;
    logic signed [KIP:0]   kisum;
    logic signed [KPP-1:0] kpprod;
    logic signed [KPP:0]   kpsum;
    logic signed [IW-1:0]  isum;
    logic signed [31:0]    integ_new;
    logic [EW-1:0]         est_sum;
    logic [PB-1:0]         est_next, sph_next;
    logic [PB+6:0]         scaled;
    logic [33:0]           kp_full;
    logic [49:0]           ki_full;

    function automatic logic [F-1:0] to_phase(input logic [31:0] v);
        logic [63:0] t;
        t = (64'(v) << SL) >> SR;
        return t[F-1:0];
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] x);
        logic signed [CW+16:0] m;
        logic signed [CW+16:0] v;
        m = ((CW+17)'(x) <<< 15) - (CW+17)'(x) + (CW+17)'(2**29);
        v = m >>> 30;
        if (v > (CW+17)'(32767))
            return 16'sd32767;
        else if (v < -(CW+17)'(32768))
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return (v == -16'sd32768) ? 16'sd32767 : -v;
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg   <= RST_PHASE_INC;
            scale_reg <= RST_NCO_SCALE;
            adj_reg   <= RST_PHASE_ADJ;
            bw_reg    <= RST_LOOP_BW;
        end else if (psel && penable && pwrite) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_PHASE_INC: inc_reg   <= pwdata;
                REG_NCO_SCALE: scale_reg <= pwdata[6:0];
                REG_PHASE_ADJ: adj_reg   <= pwdata;
                REG_LOOP_BW:   bw_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_PHASE_INC: prdata = inc_reg;
            REG_NCO_SCALE: prdata = {25'd0, scale_reg};
            REG_PHASE_ADJ: prdata = adj_reg;
            REG_LOOP_BW:   prdata = {16'd0, bw_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- shared CORDIC ----------------
    plln_cordic #(
        .CW    (CW),
        .ZW    (ZW),
        .FRAC  (F),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .x_in    (cx_in),
        .y_in    (cy_in),
        .z_in    (cz_in),
        .stat    (stat),
        .x_out   (cx_out),
        .y_out   (cy_out),
        .z_out   (cz_out)
    );

    // ---------------- combinational datapath ----------------
    always_comb begin
        accept   = s_valid && s_ready;
        vec_zero = (px_reg == '0) && (py_reg == '0);
        // left half-plane: measure from the half turn
        if (px_reg < 0) begin
            vx = -CW'(px_reg);
            vy = -CW'(py_reg);
        end else begin
            vx = CW'(px_reg);
            vy = CW'(py_reg);
        end

        // quarter-turn reduction for sine/cosine
        tp    = (state_reg == ST_ROT1_GO) ? arg_reg[F-1:0] : oph_reg;
        tsum  = tp + (F'(1) << (F - 3));
        tq    = tsum[F-1:F-2];
        tdiff = tp - {tq, (F-2)'(0)};

        cmd.start     = 1'b0;
        cmd.vectoring = 1'b0;
        cx_in         = CW'($signed({1'b0, CORDIC_X0}));
        cy_in         = '0;
        cz_in         = {{2{tdiff[F-1]}}, tdiff};
        if (state_reg == ST_VEC_GO) begin
            cmd.start     = !vec_zero;
            cmd.vectoring = 1'b1;
            cx_in         = vx;
            cy_in         = vy;
            cz_in         = (px_reg < 0) ? (ZW'(1) << (F - 1)) : '0;
        end else if (state_reg == ST_ROT1_GO || state_reg == ST_ROT2_GO) begin
            cmd.start = 1'b1;
        end

        cr = to_q15(cx_out);
        sr = to_q15(cy_out);
        case (q_reg)
            2'd0: begin tc = cr;          ts = sr;          end
            2'd1: begin tc = neg_sat(sr); ts = cr;          end
            2'd2: begin tc = neg_sat(cr); ts = neg_sat(sr); end
            default: begin tc = sr;       ts = neg_sat(cr); end
        endcase

        kp_full = 34'(bw_reg) * 34'(KP_COEF) + 34'(32768);
        ki_full = 50'(sq_reg) * 50'(KI_COEF) + 50'(2**27);

        kiprod = $signed({1'b0, ki_reg}) * err_reg;
        kisum  = {kiprod[KIP-1], kiprod} + (KIP+1)'(2**19);
        kpprod = $signed({1'b0, kp_reg}) * err_reg;
        kpsum  = {kpprod[KPP-1], kpprod} + (KPP+1)'(32768);

        isum = IW'(integ_reg) + IW'(kiterm_reg);
        if (isum > SAT_HI)
            integ_new = 32'sh7FFF_FFFF;
        else if (isum < SAT_LO)
            integ_new = -32'sh8000_0000;
        else
            integ_new = 32'(isum);

        est_sum  = EW'(est_reg) + EW'(kpterm_reg) + EW'(integ_new);
        est_next = est_sum[PB-1:0];
        sph_next = sph_reg + PB'(to_phase(inc_reg));
        scaled   = (PB+7)'(arg_reg) * (PB+7)'(scale_reg);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready)
                    state_next = ST_MUL_X;
            end
            ST_MUL_X:     state_next = ST_MUL_Y;
            ST_MUL_Y:     state_next = ST_VEC_GO;
            ST_VEC_GO:    state_next = vec_zero ? ST_GAIN_KP : ST_VEC_WAIT;
            ST_VEC_WAIT:  if (stat.done) state_next = ST_GAIN_KP;
            ST_GAIN_KP:   state_next = ST_GAIN_SQ;
            ST_GAIN_SQ:   state_next = ST_GAIN_KI;
            ST_GAIN_KI:   state_next = ST_ERR_KI;
            ST_ERR_KI:    state_next = ST_ERR_KP;
            ST_ERR_KP:    state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_ROT1_GO;
            ST_ROT1_GO:   state_next = ST_ROT1_WAIT;
            ST_ROT1_WAIT: if (stat.done) state_next = ST_ROT1_FIN;
            ST_ROT1_FIN:  state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_ROT2_GO;
            ST_ROT2_GO:   state_next = ST_ROT2_WAIT;
            ST_ROT2_WAIT: if (stat.done) state_next = ST_ROT2_FIN;
            ST_ROT2_FIN:  state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // loop state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg   <= '0;
            est_reg     <= '0;
            sph_reg     <= '0;
            fc_reg      <= TRIG_ONE;
            fs_reg      <= '0;
            hc_reg      <= TRIG_ONE;
            hs_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
                m_cos_reg   <= hc_reg;
                m_sin_reg   <= hs_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_UPDATE) begin
                integ_reg <= integ_new;
                est_reg   <= est_next;
                sph_reg   <= sph_next;
            end
            if (state_reg == ST_ROT1_FIN) begin
                fc_reg <= tc;
                fs_reg <= ts;
            end
            if (state_reg == ST_ROT2_FIN) begin
                hc_reg <= tc;
                hs_reg <= ts;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (accept)
            smp_reg <= s_sample;
        case (state_reg)
            ST_MUL_X: px_reg <= PW'(smp_reg) * PW'(fc_reg);
            ST_MUL_Y: py_reg <= -(PW'(smp_reg) * PW'(fs_reg));
            ST_VEC_GO: if (vec_zero) err_reg <= '0;
            ST_VEC_WAIT: if (stat.done) err_reg <= cz_out[F-1:0];
            ST_GAIN_KP: kp_reg <= kp_full[33:16];
            ST_GAIN_SQ: sq_reg <= 32'(bw_reg) * 32'(bw_reg);
            ST_GAIN_KI: ki_reg <= ki_full[49:28];
            ST_ERR_KI:  kiterm_reg <= kisum[KIP:20];
            ST_ERR_KP:  kpterm_reg <= kpsum[KPP:16];
            ST_UPDATE:  arg_reg <= sph_next + est_next;
            ST_ROT1_GO: q_reg <= tq;
            ST_SCALE:   oph_reg <= scaled[F+3:4] + to_phase(adj_reg);
            ST_ROT2_GO: q_reg <= tq;
            default: ;
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_nco_cos = m_cos_reg;
    assign m_nco_sin = m_sin_reg;

endmodule
`default_nettype wire

>>> hdl/plln_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plln_checker
// Port-level checks for the pilot PLL / NCO, bound to the top level.
// ----------------------------------------------------------------------------
module plln_checker import plln_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_nco_cos,
    input wire logic               pready
);

    // a sample beat always yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after sample beat");

    // one sample at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample accepted while busy");

    // never ready for a sample while a stalled result would be overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(m_valid && !m_ready))
        else $error("ready with stalled result");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_nco_cos))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind pilot_pll_quadrature_nco plln_checker u_plln_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_nco_cos (m_nco_cos),
    .pready    (pready)
);
`default_nettype wire
